// ===== rtl/rprd_pkg.sv =====
// Shared types and constants for the radio packet receive deframer.
// Depends on nothing; every rtl file except rprd_stream_if imports it.
package rprd_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMISC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_SENT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_REQ    = 3'd5;

  // Frame length limits: hard clamp and header size.
  localparam logic [6:0] LEN_LIMIT  = 7'd66;
  localparam logic [6:0] HEADER_LEN = 7'd5;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Register reset values.
  localparam logic [15:0] BCAST_RESET    = 16'd255;
  localparam logic [7:0]  ACK_SENT_RESET = 8'd128;
  localparam logic [7:0]  ACK_REQ_RESET  = 8'd64;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] node_address;
    logic [15:0] broadcast_address;
    logic        promiscuous;
    logic [6:0]  max_frame_len;
    logic [7:0]  ack_sent_mask;
    logic [7:0]  ack_req_mask;
  } cfg_t;

  // One received FIFO word.
  typedef struct packed {
    logic       frame_start;
    logic [7:0] rx_byte;
  } rx_word_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic [5:0]  data_len;
    logic [15:0] dest_id;
    logic [15:0] source_id;
    logic        ack_seen;
    logic        ack_wanted;
    logic        last;
  } res_word_t;

endpackage

// ===== rtl/rprd_stream_if.sv =====
// Valid/ready stream interface used for the byte input and the result output.
// The payload type is given per instance; no other dependencies.
interface rprd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rprd_cfg_regs.sv =====
// Configuration register file of the deframer, written through a plain port.
// Depends on rprd_pkg.
module rprd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [rprd_pkg::CFG_IDX_W-1:0]  index,
  input  logic [rprd_pkg::CFG_DATA_W-1:0] wdata,
  output rprd_pkg::cfg_t                  cfg
);
  import rprd_pkg::*;

  // Each write lands in one register, masked to its width; other indexes do nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address      <= '0;
      cfg.broadcast_address <= BCAST_RESET;
      cfg.promiscuous       <= 1'b0;
      cfg.max_frame_len     <= LEN_LIMIT;
      cfg.ack_sent_mask     <= ACK_SENT_RESET;
      cfg.ack_req_mask      <= ACK_REQ_RESET;
    end else if (we) begin
      unique case (index)
        CFG_NODE_ADDR:  cfg.node_address      <= wdata;
        CFG_BCAST_ADDR: cfg.broadcast_address <= wdata;
        CFG_PROMISC:    cfg.promiscuous       <= wdata[0];
        CFG_MAX_LEN:    cfg.max_frame_len     <= wdata[6:0];
        CFG_ACK_SENT:   cfg.ack_sent_mask     <= wdata[7:0];
        CFG_ACK_REQ:    cfg.ack_req_mask      <= wdata[7:0];
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== rtl/rprd_hdr_fsm.sv =====
// Header parsing state machine: consumes one registered byte per step and
// decides the result word for it. Depends on rprd_pkg.
module rprd_hdr_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  rprd_pkg::rx_word_t   word,
  input  rprd_pkg::cfg_t       cfg,
  output logic                 has_res,
  output rprd_pkg::res_word_t  res
);
  import rprd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TGT_HI, PH_TGT_LO, PH_SND_HI,
    PH_SND_LO, PH_CTL, PH_PAYLOAD, PH_DISCARD
  } phase_t;

  phase_t      phase, phase_next;
  logic [6:0]  frame_length, frame_length_next;
  logic [5:0]  payload_count, payload_count_next;
  logic [15:0] target_id, target_id_next;
  logic [15:0] sender_id, sender_id_next;
  logic [1:0]  ack_flags, ack_flags_next;

  logic [6:0]  len_lim;
  logic [5:0]  dlen;
  logic [15:0] tgt_full;
  logic        addr_ok;
  logic        ackr, ackq;
  logic        is_last;

  // Values derived from the current byte and state.
  always_comb begin
    len_lim  = (cfg.max_frame_len > LEN_LIMIT) ? LEN_LIMIT : cfg.max_frame_len;
    dlen     = (frame_length >= HEADER_LEN) ? 6'(frame_length - HEADER_LEN) : '0;
    tgt_full = {target_id[15:8], word.rx_byte};
    addr_ok  = cfg.promiscuous || (tgt_full == cfg.node_address) ||
               (tgt_full == cfg.broadcast_address);
    ackr     = |(word.rx_byte & cfg.ack_sent_mask);
    ackq     = (|(word.rx_byte & cfg.ack_req_mask)) &&
               (target_id != cfg.broadcast_address);
    is_last  = ({1'b0, payload_count} + 7'd1) >= {1'b0, dlen};
  end

  // Next state and the result for this byte.
  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    target_id_next     = target_id;
    sender_id_next     = sender_id;
    ack_flags_next     = ack_flags;
    has_res            = 1'b0;
    res                = '0;
    res.dest_id        = target_id;

    if (word.frame_start) begin
      // A length byte always opens a new frame, dropping any unfinished one.
      frame_length_next  = (word.rx_byte > {1'b0, len_lim}) ? len_lim : word.rx_byte[6:0];
      payload_count_next = '0;
      target_id_next     = '0;
      sender_id_next     = '0;
      ack_flags_next     = '0;
      phase_next         = PH_TGT_HI;
    end else begin
      unique case (phase)
        PH_TGT_HI: begin
          target_id_next = {word.rx_byte, 8'd0};
          phase_next     = PH_TGT_LO;
        end
        PH_TGT_LO: begin
          target_id_next = tgt_full;
          if (!addr_ok || (frame_length < HEADER_LEN)) begin
            phase_next  = PH_DISCARD;
            has_res     = 1'b1;
            res.kind    = KIND_REJECT;
            res.dest_id = tgt_full;
            res.last    = 1'b1;
          end else begin
            phase_next = PH_SND_HI;
          end
        end
        PH_SND_HI: begin
          sender_id_next = {word.rx_byte, 8'd0};
          phase_next     = PH_SND_LO;
        end
        PH_SND_LO: begin
          sender_id_next = {sender_id[15:8], word.rx_byte};
          phase_next     = PH_CTL;
        end
        PH_CTL: begin
          ack_flags_next     = {ackq, ackr};
          payload_count_next = '0;
          if (dlen == '0) begin
            phase_next     = PH_IDLE;
            has_res        = 1'b1;
            res.kind       = KIND_EMPTY;
            res.source_id  = sender_id;
            res.ack_seen   = ackr;
            res.ack_wanted = ackq;
            res.last       = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          has_res          = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = word.rx_byte;
          res.byte_index   = payload_count;
          res.data_len     = dlen;
          res.source_id    = sender_id;
          res.ack_seen     = ack_flags[0];
          res.ack_wanted   = ack_flags[1];
          res.last         = is_last;
          if (is_last) begin
            phase_next         = PH_IDLE;
            payload_count_next = '0;
          end else begin
            payload_count_next = payload_count + 6'd1;
          end
        end
        PH_IDLE, PH_DISCARD: begin
          // Bytes outside a frame are dropped.
        end
      endcase
    end
  end

  // State registers advance once per consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_length  <= '0;
      payload_count <= '0;
      target_id     <= '0;
      sender_id     <= '0;
      ack_flags     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      target_id     <= target_id_next;
      sender_id     <= sender_id_next;
      ack_flags     <= ack_flags_next;
    end
  end
endmodule

// ===== rtl/rprd_out_reg.sv =====
// Result register: holds one result word until the downstream side takes it.
// Depends on rprd_pkg.
module rprd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rprd_pkg::res_word_t load_data,
  input  logic                take,
  output logic                valid,
  output rprd_pkg::res_word_t data
);
  import rprd_pkg::*;

  logic valid_next;

  // A load wins over a take in the same cycle, keeping the stage full.
  always_comb begin
    if (load) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // The payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end
endmodule

// ===== rtl/radio_packet_rx_deframer_unit.sv =====
// Top level of the radio packet receive deframer.
// Depends on rprd_pkg, rprd_stream_if, rprd_cfg_regs, rprd_hdr_fsm, rprd_out_reg.
//
//   Channel  Direction  Word         Handshake
//   rx       in         rx_word_t    rx.valid / rx.ready
//   res      out        res_word_t   res.valid / res.ready
//   cfg      in         index, data  cfg_we only
//
// One byte is accepted per cycle while the parser does not stall. An accepted byte
// is loaded into the input register first; when the parser consumes it, its result
// word, if any, goes into the result register. Reset clears the input and result
// valid bits, the parser phase and the registers to their defaults. While a
// result waits, an empty input register still takes a byte; the parser stalls
// only when the result register is full and not being taken.
module radio_packet_rx_deframer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rprd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rprd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rprd_stream_if.sink                     rx,
  rprd_stream_if.source                   res
);
  import rprd_pkg::*;

  cfg_t      cfg;
  logic      in_valid;
  rx_word_t  in_word;
  logic      step;
  logic      has_res;
  res_word_t res_next;

  rprd_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // The parser consumes the held byte whenever the result stage can take a word.
  assign step     = in_valid && (!res.valid || res.ready);
  assign rx.ready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_word <= rx.data;
    end
  end

  rprd_hdr_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .word    (in_word),
    .cfg     (cfg),
    .has_res (has_res),
    .res     (res_next)
  );

  rprd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && has_res),
    .load_data (res_next),
    .take      (res.ready),
    .valid     (res.valid),
    .data      (res.data)
  );
endmodule

// ===== rtl/rprd_checker.sv =====
// Port-level checks for the deframer top level, attached by bind.
// Depends on rprd_pkg and radio_packet_rx_deframer_unit.
module rprd_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input rprd_pkg::res_word_t res_data
);
  import rprd_pkg::*;

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result stays and holds its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // Empty and rejected frames always close the frame.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind == KIND_EMPTY || res_data.kind == KIND_REJECT)
      |-> res_data.last)
    else $error("single-word frame result without last");

  // A rejected frame carries no sender or length information.
  a_reject_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == KIND_REJECT
      |-> res_data.source_id == '0 && res_data.data_len == '0 &&
          !res_data.ack_seen && !res_data.ack_wanted)
    else $error("rejected frame carries header fields");

  // Payload indexes stay inside the payload, and the last one closes it.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == KIND_PAYLOAD
      |-> res_data.byte_index < res_data.data_len &&
          res_data.last == ({1'b0, res_data.byte_index} + 7'd1 == {1'b0, res_data.data_len}))
    else $error("payload index out of range or last misplaced");
endmodule

bind radio_packet_rx_deframer_unit rprd_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

// ===== verif/radio_packet_rx_deframer_unit_tb.sv =====
// Self-checking testbench for the radio packet receive deframer.
// Depends on rprd_pkg, rprd_stream_if and the radio_packet_rx_deframer_unit RTL;
// a cycle-free predictor of the header parser checks every result word.
`timescale 1ns / 1ps

module radio_packet_rx_deframer_unit_tb;
  import rprd_pkg::*;

  // Run controls.
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned PIPE_SETTLE  = 6;
  localparam int unsigned REPORT_LIMIT = 10;

  // An index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    PS_IDLE,
    PS_TGT_HI,
    PS_TGT_LO,
    PS_SND_HI,
    PS_SND_LO,
    PS_CTL,
    PS_PAYLOAD,
    PS_DISCARD
  } parse_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rprd_stream_if #(.payload_t(rx_word_t)) rx_if ();
  rprd_stream_if #(.payload_t(res_word_t)) res_if ();

  radio_packet_rx_deframer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_if),
    .res       (res_if)
  );

  // Words waiting to be sent and results the parser should produce.
  rx_word_t  pending_words[$];
  res_word_t expected_results[$];

  // Shadow copy of the registers and of the parser state.
  cfg_t         shadow_cfg;
  parse_state_t parse_state;
  logic [6:0]   frm_len;
  logic [5:0]   pay_cnt;
  logic [15:0]  tgt_id;
  logic [15:0]  snd_id;
  logic [1:0]   ack_bits;

  // Bookkeeping.
  int mismatches = 0;
  int accepted_words = 0;
  int payload_results = 0;
  int empty_results = 0;
  int reject_results = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  int rx_gap = 0;
  int res_stall = 0;
  bit rx_calm = 1'b0;
  bit res_calm = 1'b0;

  // Clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Pause length: mostly none or short, now and then long.
  function automatic int pick_pause(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic string show_result(input res_word_t r);
    return {$sformatf("kind=%0d byte=%02h idx=%0d len=%0d dst=%04h ",
                      r.kind, r.payload_byte, r.byte_index, r.data_len, r.dest_id),
            $sformatf("src=%04h ackr=%0b ackq=%0b last=%0b",
                      r.source_id, r.ack_seen, r.ack_wanted, r.last)};
  endfunction

  // Parser prediction for one accepted word.
  task automatic deframe_word(input rx_word_t w);
    logic [6:0] clamp;
    int pay_len;
    logic hit;
    logic ack_r;
    logic ack_q;
    logic fin;
    res_word_t r;
    r = '0;
    pay_len = (frm_len >= HEADER_LEN) ? int'(frm_len - HEADER_LEN) : 0;
    if (w.frame_start) begin
      // A length byte always opens a new frame, dropping any unfinished one.
      clamp = (shadow_cfg.max_frame_len > LEN_LIMIT) ? LEN_LIMIT : shadow_cfg.max_frame_len;
      if (w.rx_byte > {1'b0, clamp}) frm_len = clamp;
      else frm_len = w.rx_byte[6:0];
      pay_cnt = '0;
      tgt_id = '0;
      snd_id = '0;
      ack_bits = '0;
      parse_state = PS_TGT_HI;
    end else begin
      case (parse_state)
        PS_TGT_HI: begin
          tgt_id = {w.rx_byte, 8'h00};
          parse_state = PS_TGT_LO;
        end
        PS_TGT_LO: begin
          tgt_id = {tgt_id[15:8], w.rx_byte};
          hit = shadow_cfg.promiscuous || tgt_id == shadow_cfg.node_address ||
                tgt_id == shadow_cfg.broadcast_address;
          if (!hit || frm_len < HEADER_LEN) begin
            parse_state = PS_DISCARD;
            r.kind = KIND_REJECT;
            r.dest_id = tgt_id;
            r.last = 1'b1;
            expected_results.push_back(r);
          end else begin
            parse_state = PS_SND_HI;
          end
        end
        PS_SND_HI: begin
          snd_id = {w.rx_byte, 8'h00};
          parse_state = PS_SND_LO;
        end
        PS_SND_LO: begin
          snd_id = {snd_id[15:8], w.rx_byte};
          parse_state = PS_CTL;
        end
        PS_CTL: begin
          ack_r = |(w.rx_byte & shadow_cfg.ack_sent_mask);
          ack_q = |(w.rx_byte & shadow_cfg.ack_req_mask) &&
                  tgt_id != shadow_cfg.broadcast_address;
          ack_bits = {ack_q, ack_r};
          pay_cnt = '0;
          if (pay_len == 0) begin
            parse_state = PS_IDLE;
            r.kind = KIND_EMPTY;
            r.dest_id = tgt_id;
            r.source_id = snd_id;
            r.ack_seen = ack_r;
            r.ack_wanted = ack_q;
            r.last = 1'b1;
            expected_results.push_back(r);
          end else begin
            parse_state = PS_PAYLOAD;
          end
        end
        PS_PAYLOAD: begin
          fin = (int'(pay_cnt) + 1 >= pay_len);
          r.kind = KIND_PAYLOAD;
          r.payload_byte = w.rx_byte;
          r.byte_index = pay_cnt;
          r.data_len = pay_len[5:0];
          r.dest_id = tgt_id;
          r.source_id = snd_id;
          r.ack_seen = ack_bits[0];
          r.ack_wanted = ack_bits[1];
          r.last = fin;
          expected_results.push_back(r);
          if (fin) begin
            parse_state = PS_IDLE;
            pay_cnt = '0;
          end else begin
            pay_cnt = pay_cnt + 6'd1;
          end
        end
        default: ;
      endcase
    end
  endtask

  // Compare one result word against the oldest expectation.
  task automatic check_result(input res_word_t got);
    res_word_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("ERROR: result with nothing expected: %s", show_result(got));
    end else begin
      want = expected_results.pop_front();
      if (want.kind !== got.kind || want.payload_byte !== got.payload_byte ||
          want.byte_index !== got.byte_index || want.data_len !== got.data_len ||
          want.dest_id !== got.dest_id || want.source_id !== got.source_id ||
          want.ack_seen !== got.ack_seen ||
          want.ack_wanted !== got.ack_wanted || want.last !== got.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR: result mismatch");
          $display("  expected %s", show_result(want));
          $display("  actual   %s", show_result(got));
        end
      end
    end
    case (got.kind)
      KIND_PAYLOAD: payload_results++;
      KIND_EMPTY:   empty_results++;
      default:      reject_results++;
    endcase
  endtask

  // Byte driver: presents queued words, with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
      rx_if.data <= '0;
      rx_gap <= 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_word(rx_if.data);
        accepted_words++;
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_gap > 0) begin
          rx_gap <= rx_gap - 1;
          rx_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          rx_if.valid <= 1'b1;
          rx_if.data <= pending_words.pop_front();
          rx_gap <= pick_pause(rx_calm);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks every taken word and stalls ready at random.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      res_stall <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        check_result(res_if.data);
        if ($urandom_range(0, 49) == 0) res_calm = !res_calm;
      end
      if (res_stall > 0) begin
        res_stall <= res_stall - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        res_stall <= pick_pause(res_calm);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_word(input logic start, input logic [7:0] b);
    rx_word_t w;
    w.frame_start = start;
    w.rx_byte = b;
    pending_words.push_back(w);
  endtask

  // Queue the first count words of a frame header (length .. control byte).
  task automatic queue_header(input logic [7:0] len_byte, input logic [15:0] dst,
                              input logic [15:0] src, input logic [7:0] ctl,
                              input int count);
    logic [7:0] hdr[6];
    hdr[0] = len_byte;
    hdr[1] = dst[15:8];
    hdr[2] = dst[7:0];
    hdr[3] = src[15:8];
    hdr[4] = src[7:0];
    hdr[5] = ctl;
    for (int i = 0; i < count && i < 6; i++) queue_word(i == 0, hdr[i]);
  endtask

  // One random frame: mostly well formed and short, some truncated.
  task automatic queue_random_frame();
    int roll;
    int lim;
    int clen;
    int total;
    int count;
    logic [7:0] len_byte;
    logic [15:0] dst;
    roll = $urandom_range(0, 99);
    if (roll < 70) len_byte = 8'($urandom_range(5, 12));
    else if (roll < 80) len_byte = 8'($urandom_range(0, 4));
    else if (roll < 92) len_byte = 8'($urandom_range(13, 66));
    else len_byte = 8'($urandom_range(67, 255));
    roll = $urandom_range(0, 99);
    if (roll < 45) dst = shadow_cfg.node_address;
    else if (roll < 70) dst = shadow_cfg.broadcast_address;
    else dst = 16'($urandom_range(0, 65535));
    lim = (shadow_cfg.max_frame_len > LEN_LIMIT) ? int'(LEN_LIMIT) :
          int'(shadow_cfg.max_frame_len);
    clen = (int'(len_byte) > lim) ? lim : int'(len_byte);
    total = 6 + ((clen >= int'(HEADER_LEN)) ? clen - int'(HEADER_LEN) : $urandom_range(0, 3));
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : total;
    queue_header(len_byte, dst, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 count);
    for (int i = 6; i < count; i++) queue_word(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // Random traffic of about n words: frames with some stray words between.
  task automatic queue_random_traffic(input int n);
    int goal;
    goal = pending_words.size() + accepted_words + n;
    while (pending_words.size() + accepted_words < goal) begin
      if ($urandom_range(0, 7) == 0)
        queue_word($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
      else
        queue_random_frame();
    end
  endtask

  // Wait until every word is sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || rx_if.valid || expected_results.size() != 0);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Register write; the shadow copy follows the register widths.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_NODE_ADDR:  shadow_cfg.node_address = val;
      CFG_BCAST_ADDR: shadow_cfg.broadcast_address = val;
      CFG_PROMISC:    shadow_cfg.promiscuous = val[0];
      CFG_MAX_LEN:    shadow_cfg.max_frame_len = val[6:0];
      CFG_ACK_SENT:   shadow_cfg.ack_sent_mask = val[7:0];
      CFG_ACK_REQ:    shadow_cfg.ack_req_mask = val[7:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Upper bits above a register's width carry junk that must be dropped.
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int width, input int val);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom_range(0, 65535));
    return (junk << width) | CFG_DATA_W'(val);
  endfunction

  // Main sequence.
  initial begin
    shadow_cfg.node_address = '0;
    shadow_cfg.broadcast_address = BCAST_RESET;
    shadow_cfg.promiscuous = 1'b0;
    shadow_cfg.max_frame_len = LEN_LIMIT;
    shadow_cfg.ack_sent_mask = ACK_SENT_RESET;
    shadow_cfg.ack_req_mask = ACK_REQ_RESET;
    parse_state = PS_IDLE;
    frm_len = '0;
    pay_cnt = '0;
    tgt_id = '0;
    snd_id = '0;
    ack_bits = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset register values.
    queue_word(1'b0, 8'hFF);                          // stray byte while idle
    queue_header(8'd5, 16'h0000, 16'hFFFF, 8'hFF, 6); // empty frame, both acks
    queue_header(8'd4, 16'h00FF, 16'h0000, 8'h00, 3); // too short: rejected
    queue_word(1'b0, 8'hAA);                          // discarded remainder
    queue_header(8'd9, 16'h1234, 16'h0000, 8'h00, 3); // foreign target: rejected
    queue_header(8'd7, 16'h00FF, 16'h8001, 8'h40, 6); // broadcast hides ack request
    queue_word(1'b0, 8'h00);
    queue_word(1'b0, 8'hFF);
    queue_header(8'hFF, 16'h0000, 16'h0000, 8'h00, 2); // clamped, cut by a new start
    queue_header(8'd6, 16'h0000, 16'h7F00, 8'h80, 6);
    queue_word(1'b0, 8'h5A);
    wait_drained();

    // Random addresses and masks, full length.
    write_reg(CFG_NODE_ADDR, 16'($urandom_range(0, 65535)));
    write_reg(CFG_BCAST_ADDR, 16'($urandom_range(0, 65535)));
    write_reg(CFG_PROMISC, with_junk(1, 0));
    write_reg(CFG_MAX_LEN, with_junk(7, 66));
    write_reg(CFG_ACK_SENT, with_junk(8, $urandom_range(0, 255)));
    write_reg(CFG_ACK_REQ, with_junk(8, $urandom_range(0, 255)));
    end_writes();
    queue_random_traffic(150);
    wait_drained();

    // Promiscuous, shortest frames, no ack bits.
    write_reg(CFG_PROMISC, with_junk(1, 1));
    write_reg(CFG_MAX_LEN, with_junk(7, 5));
    write_reg(CFG_ACK_SENT, with_junk(8, 0));
    write_reg(CFG_ACK_REQ, with_junk(8, 0));
    end_writes();
    queue_random_traffic(80);
    wait_drained();

    // Extreme addresses, clamp above the hard limit, all mask bits.
    write_reg(CFG_PROMISC, with_junk(1, 0));
    write_reg(CFG_NODE_ADDR, 16'hFFFF);
    write_reg(CFG_BCAST_ADDR, 16'h0000);
    write_reg(CFG_MAX_LEN, with_junk(7, 127));
    write_reg(CFG_ACK_SENT, with_junk(8, 255));
    write_reg(CFG_ACK_REQ, with_junk(8, 255));
    write_reg(CFG_UNUSED_IDX, 16'($urandom_range(0, 65535)));
    end_writes();
    queue_random_traffic(150);
    wait_drained();

    // Clamp below the header size: every frame that reaches its target is rejected.
    write_reg(CFG_PROMISC, with_junk(1, 1));
    write_reg(CFG_MAX_LEN, with_junk(7, 0));
    end_writes();
    queue_random_traffic(20);
    wait_drained();

    // Random setting; the sender halts midway until all results are back.
    write_reg(CFG_NODE_ADDR, 16'($urandom_range(0, 65535)));
    write_reg(CFG_BCAST_ADDR, 16'($urandom_range(0, 65535)));
    write_reg(CFG_PROMISC, with_junk(1, $urandom_range(0, 1)));
    write_reg(CFG_MAX_LEN, with_junk(7, $urandom_range(5, 66)));
    write_reg(CFG_ACK_SENT, with_junk(8, 1 << $urandom_range(0, 7)));
    write_reg(CFG_ACK_REQ, with_junk(8, 1 << $urandom_range(0, 7)));
    end_writes();
    queue_random_traffic(100);
    wait_drained();
    queue_random_traffic(100);
    wait_drained();

    repeat (PIPE_SETTLE) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("Sent %0d words; checked %0d payload bytes, %0d empty and %0d rejected frames.",
             accepted_words, payload_results, empty_results, reject_results);
    $display("Used %0d register settings, from an all-reject clamp to a saturated one.",
             settings_used);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
